// ===== rtl/core/pgd_pkg.sv =====
`timescale 1ns / 1ps
package pgd_pkg;

	localparam int MAX_WIDTH     = 2048;
	localparam int PALETTE_DEPTH = 256;
	localparam int Q_DEPTH       = 4;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam int PIX_X_W = 11;
	localparam int PIX_Y_W = 16;

	// input word kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_PALW  = 2'd1;
	localparam logic [1:0] KIND_DATA  = 2'd2;

	// filter modes
	localparam logic [1:0] MODE_COPY     = 2'd0;
	localparam logic [1:0] MODE_PALETTE  = 2'd1;
	localparam logic [1:0] MODE_GRADIENT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_COLORS = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	typedef enum logic [2:0] {
		OP_START,
		OP_PALW,
		OP_IDX,
		OP_BITS,
		OP_RGB,
		OP_GRAD
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  idx;
		logic [23:0] data;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  colors;
		logic [11:0] width;
		logic [15:0] height;
	} cfg_t;

endpackage

// ===== rtl/core/pgd_front.sv =====
`timescale 1ns / 1ps
module pgd_front import pgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_color,
	input  logic [7:0]  data_byte,
	input  cfg_t        cfg,
	input  logic        q_full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [1:0]  phase_q, phase_d;
	logic [15:0] partial_q, partial_d;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		push      = 1'b0;
		push_cmd  = '{op: OP_START, idx: palette_index, data: palette_color};
		phase_d   = phase_q;
		partial_d = partial_q;
		if (accept) begin
			case (kind)
				KIND_START: begin
					push      = 1'b1;
					phase_d   = '0;
					partial_d = '0;
				end
				KIND_PALW: begin
					push        = 1'b1;
					push_cmd.op = OP_PALW;
				end
				KIND_DATA: begin
					if (cfg.mode == MODE_PALETTE) begin
						push         = 1'b1;
						push_cmd.idx = data_byte;
						push_cmd.op  = (cfg.colors <= 9'd2) ? OP_BITS : OP_IDX;
					end else if (phase_q < 2'd2) begin
						// collect R and G, hold until the blue byte arrives
						partial_d = {partial_q[7:0], data_byte};
						phase_d   = phase_q + 2'd1;
					end else begin
						push          = 1'b1;
						push_cmd.op   = (cfg.mode == MODE_GRADIENT) ? OP_GRAD : OP_RGB;
						push_cmd.data = {partial_q, data_byte};
						phase_d       = '0;
						partial_d     = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			partial_q <= '0;
		end else begin
			phase_q   <= phase_d;
			partial_q <= partial_d;
		end
	end

endmodule

// ===== rtl/core/pgd_queue.sv =====
`timescale 1ns / 1ps
module pgd_queue import pgd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	cmd_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q, rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_push, do_pop;

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/pgd_back.sv =====
`timescale 1ns / 1ps
module pgd_back import pgd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                q_valid,
	input  cmd_t                q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         pixel_color,
	output logic [PIX_X_W-1:0]  pixel_x,
	output logic [PIX_Y_W-1:0]  pixel_y,
	output logic                last_of_item,
	output logic                rect_done
);

	localparam logic [12:0] MAXW    = 13'(MAX_WIDTH);
	localparam logic [8:0]  PAL_LIM = 9'(PALETTE_DEPTH);

	function automatic logic [23:0] grad_px(input logic [23:0] up, input logic [23:0] lf,
		input logic [23:0] ul, input logic [23:0] resid);
		logic [9:0]  est;
		logic [7:0]  clp;
		logic [23:0] r;
		r = '0;
		for (int c = 0; c < 3; c++) begin
			est = {2'b0, up[8*c +: 8]} + {2'b0, lf[8*c +: 8]} - {2'b0, ul[8*c +: 8]};
			if (est[9])      clp = 8'h00;
			else if (est[8]) clp = 8'hFF;
			else             clp = est[7:0];
			r[8*c +: 8] = clp + resid[8*c +: 8];
		end
		return r;
	endfunction

	logic [23:0] pal_mem [PALETTE_DEPTH];
	logic [23:0] up_mem  [MAX_WIDTH];

	logic              finished_q;
	logic [COL_W-1:0]  col_q;
	logic [15:0]       row_q;
	logic [2:0]        bit_q;
	logic [23:0]       left_q, ul_q;
	logic              out_valid_q;

	logic              en, is_pix, is_bits, wrap, done, last, bitsel;
	logic [12:0]       w_now;
	logic [15:0]       newrow;
	logic [PAL_AW-1:0] pal_addr;
	logic              pal_ok, pal_we, up_we;

	logic              valid_s1, grad_s1, pal_s1, pal_ok_s1, last_s1, done_s1, clr_s1;
	logic              row_nz_s1, fwd_s1;
	logic [23:0]       rgb_s1, pal_rd_s1, up_rd_s1, fwd_data_s1;
	logic [COL_W-1:0]  x_s1;
	logic [15:0]       y_s1;
	logic [23:0]       upper, gres, color;

	// issue side: position bookkeeping and memory reads
	assign en      = !out_valid_q || out_ready;
	assign is_bits = (q_head.op == OP_BITS);
	assign is_pix  = q_valid && !finished_q &&
		(q_head.op == OP_IDX || q_head.op == OP_BITS ||
		 q_head.op == OP_RGB || q_head.op == OP_GRAD);
	assign w_now   = ({1'b0, cfg.width} > MAXW) ? MAXW : {1'b0, cfg.width};
	assign wrap    = (13'(col_q) + 13'd1) >= w_now;
	assign newrow  = row_q + 16'd1;
	assign done    = wrap && (newrow == '0 || newrow >= cfg.height);
	assign last    = !is_bits || wrap || (bit_q == 3'd7);
	assign q_pop   = en && q_valid && (!is_pix || last);

	assign bitsel   = q_head.idx[3'd7 - bit_q];
	assign pal_addr = is_bits ? PAL_AW'(bitsel) : q_head.idx[PAL_AW-1:0];
	assign pal_ok   = is_bits || ({1'b0, q_head.idx} < PAL_LIM);
	assign pal_we   = en && q_valid && (q_head.op == OP_PALW) && ({1'b0, q_head.idx} < PAL_LIM);

	always_ff @(posedge clk) begin
		if (pal_we) pal_mem[q_head.idx[PAL_AW-1:0]] <= q_head.data;
		if (en)     pal_rd_s1 <= pal_mem[pal_addr];
	end

	always_ff @(posedge clk) begin
		if (up_we) up_mem[x_s1] <= gres;
		if (en)    up_rd_s1 <= up_mem[col_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finished_q <= 1'b1;
			col_q      <= '0;
			row_q      <= '0;
			bit_q      <= '0;
			valid_s1   <= 1'b0;
			clr_s1     <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (en) begin
			valid_s1 <= is_pix;
			clr_s1   <= (q_valid && q_head.op == OP_START) || (is_pix && wrap);
			fwd_s1   <= up_we && (x_s1 == col_q);
			if (q_valid && q_head.op == OP_START) begin
				finished_q <= (cfg.width == '0) || (cfg.height == '0);
				col_q      <= '0;
				row_q      <= '0;
				bit_q      <= '0;
			end else if (is_pix) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= newrow;
					if (done) finished_q <= 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (is_bits) bit_q <= last ? 3'd0 : bit_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grad_s1     <= (q_head.op == OP_GRAD);
			pal_s1      <= (q_head.op == OP_IDX) || is_bits;
			pal_ok_s1   <= pal_ok;
			rgb_s1      <= q_head.data;
			x_s1        <= col_q;
			y_s1        <= row_q;
			row_nz_s1   <= (row_q != '0);
			last_s1     <= last;
			done_s1     <= done;
			fwd_data_s1 <= gres;
		end
	end

	// second stage: gradient prediction and color select
	assign upper = !row_nz_s1 ? 24'h0 : (fwd_s1 ? fwd_data_s1 : up_rd_s1);
	assign gres  = grad_px(upper, left_q, ul_q, rgb_s1);
	assign up_we = en && valid_s1 && grad_s1;
	assign color = grad_s1 ? gres : (pal_s1 ? (pal_ok_s1 ? pal_rd_s1 : 24'h0) : rgb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			ul_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s1;
			if (clr_s1) begin
				left_q <= '0;
				ul_q   <= '0;
			end else if (valid_s1 && grad_s1) begin
				left_q <= gres;
				ul_q   <= upper;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_color  <= color;
			pixel_x      <= PIX_X_W'(x_s1);
			pixel_y      <= y_s1;
			last_of_item <= last_s1;
			rect_done    <= done_s1;
		end
	end

	assign out_valid = out_valid_q;

	a_bit_on_bits: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q != 3'd0 |-> q_valid && (q_head.op == OP_BITS))
		else $error("bit counter running without a one-bit byte at queue head");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rect_done |-> last_of_item)
		else $error("final rectangle pixel not marked last of its word");

	a_done_finish: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && done_s1 |-> finished_q)
		else $error("rectangle end issued but decoder not finished");

endmodule

// ===== rtl/core/palette_gradient_pixel_decoder.sv =====
`timescale 1ns / 1ps
// Pixel decoder for a filtered rectangle byte stream.
// Input channel (in_valid/in_ready): one word per handshake, selected by kind:
//   start rectangle, palette entry write, or one decompressed data byte.
// Output channel (out_valid/out_ready): one pixel word with its color, x/y
//   position, last_of_item (last pixel caused by an input word) and rect_done.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   only while no pixels are pending.
// Throughput: one input word per cycle while the command queue is not full.
//   Copy and gradient modes emit a pixel every third byte, palette-index
//   mode one per byte, and one-bit palette mode up to eight pixels per byte,
//   one per cycle while the receiver is ready, set by the single palette read
//   port; the four-entry command queue absorbs input during that expansion.
// Pixel path: queue write, issue with memory read, color stage, out_valid.
// Reset: decoder idle until a start word, registers at mode copy, two colors,
//   1x1 rectangle. Palette and upper-row memories are not cleared.
// Receiver stall: the output register holds the pixel and the back end stops;
//   input is still taken until the command queue fills.
module palette_gradient_pixel_decoder import pgd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          kind,
	input  logic [7:0]          palette_index,
	input  logic [23:0]         palette_color,
	input  logic [7:0]          data_byte,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [23:0]         pixel_color,
	output logic [PIX_X_W-1:0]  pixel_x,
	output logic [PIX_Y_W-1:0]  pixel_y,
	output logic                last_of_item,
	output logic                rect_done
);

	cfg_t cfg_q;
	logic q_full, q_push, q_pop, q_valid;
	cmd_t q_push_cmd, q_head;

	assign cfg_ready = 1'b1;

	// register file: take every write, drop upper bits beyond each field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_COPY;
			cfg_q.colors <= 9'd2;
			cfg_q.width  <= 12'd1;
			cfg_q.height <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   cfg_q.mode   <= cfg_data[1:0];
				REG_COLORS: cfg_q.colors <= cfg_data[8:0];
				REG_WIDTH:  cfg_q.width  <= cfg_data[11:0];
				REG_HEIGHT: cfg_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: classify words, assemble RGB triples
	pgd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.palette_index (palette_index),
		.palette_color (palette_color),
		.data_byte     (data_byte),
		.cfg           (cfg_q),
		.q_full        (q_full),
		.push          (q_push),
		.push_cmd      (q_push_cmd)
	);

	// short command queue decouples front and back stalls
	pgd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// back: positions, palette and upper-row memories, gradient, output register
	pgd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_item (last_of_item),
		.rect_done    (rect_done)
	);

endmodule

// ===== tb/palette_gradient_pixel_decoder_tb.sv =====
`timescale 1ns / 1ps
module palette_gradient_pixel_decoder_tb;
	import pgd_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int IDLE_PCT       = 13;
	localparam int SETTLE_CYCLES  = 8;     // pipeline is three deep; leave margin
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 24;
	localparam int CALM_ITEMS     = 18;
	localparam int LOADED_ENTRIES = 8;

	// codes the package leaves unnamed
	localparam logic [1:0] KIND_UNUSED   = 2'd3;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	typedef struct packed {
		logic [23:0]        color;
		logic [PIX_X_W-1:0] x;
		logic [PIX_Y_W-1:0] y;
		logic               last;
		logic               done;
	} pixel_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [1:0]         kind          = KIND_START;
	logic [7:0]         palette_index = '0;
	logic [23:0]        palette_color = '0;
	logic [7:0]         data_byte     = '0;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index     = REG_MODE;
	logic [15:0]        cfg_data      = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [23:0]        pixel_color;
	logic [PIX_X_W-1:0] pixel_x;
	logic [PIX_Y_W-1:0] pixel_y;
	logic               last_of_item;
	logic               rect_done;

	// shared between the stimulus, the receiver, the checker and the watchdog
	bit     calm     = 1'b0;   // suppress idling on both sides
	bit     hold_req = 1'b0;   // ask the receiver for one long hold-off
	int     errors   = 0;
	int     quiet_cycles = 0;
	pixel_t pending_pixels[$];

	// decoder state as this bench tracks it
	logic [23:0] upper_row [MAX_WIDTH];
	logic [23:0] colour_tbl [PALETTE_DEPTH];
	int unsigned col_cnt   = 0;
	int unsigned row_cnt   = 0;
	int unsigned phase     = 0;
	logic [15:0] partial   = '0;
	logic [23:0] left_px   = '0;
	logic [23:0] upleft_px = '0;
	bit          rect_idle = 1'b1;

	logic [1:0]  reg_mode   = MODE_COPY;
	logic [8:0]  reg_colors = 9'd2;
	logic [11:0] reg_width  = 12'd1;
	logic [15:0] reg_height = 16'd1;

	palette_gradient_pixel_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.palette_index(palette_index),
		.palette_color(palette_color),
		.data_byte    (data_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_item (last_of_item),
		.rect_done    (rect_done)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Pixel prediction
	// ------------------------------------------------------------------

	// Widths past the line buffer are clamped to it.
	function automatic int unsigned eff_width();
		return (reg_width > MAX_WIDTH) ? MAX_WIDTH : reg_width;
	endfunction

	// Queue one pixel at the current position, then advance column and row.
	task automatic push_pixel(logic [23:0] color);
		pixel_t      p;
		int unsigned w;
		w       = eff_width();
		p.color = color;
		p.x     = col_cnt[PIX_X_W-1:0];
		p.y     = row_cnt[PIX_Y_W-1:0];
		p.last  = 1'b0;
		p.done  = 1'b0;
		if (col_cnt + 1 >= w) begin
			col_cnt   = 0;
			row_cnt   = (row_cnt + 1) & 32'hFFFF;
			left_px   = '0;
			upleft_px = '0;
			// height reached, or the row counter wrapped
			if (row_cnt == 0 || row_cnt >= reg_height) begin
				rect_idle = 1'b1;
				p.done    = 1'b1;
			end
		end else begin
			col_cnt++;
		end
		pending_pixels.push_back(p);
	endtask

	// Per channel: clamp(upper + left - upper_left) plus the residual, mod 256.
	// The first row sees zero above; the first column zero on the left.
	function automatic logic [23:0] predict_gradient(logic [23:0] resid);
		logic [23:0] above;
		logic [23:0] px;
		int          est;
		above = (row_cnt != 0 && col_cnt < MAX_WIDTH) ? upper_row[col_cnt] : '0;
		for (int s = 16; s >= 0; s -= 8) begin
			est = int'(above[s +: 8]) + int'(left_px[s +: 8]) - int'(upleft_px[s +: 8]);
			if (est > 255)
				est = 255;
			else if (est < 0)
				est = 0;
			px[s +: 8] = est[7:0] + resid[s +: 8];
		end
		if (col_cnt < MAX_WIDTH)
			upper_row[col_cnt] = px;
		upleft_px = above;
		left_px   = px;
		return px;
	endfunction

	// Apply one accepted input word and queue the pixels it produces.
	task automatic decode_word(logic [1:0] k, logic [7:0] pidx, logic [23:0] pcol,
			logic [7:0] b);
		int unsigned cnt;
		int unsigned n;
		int unsigned w;
		logic [23:0] rgb;
		n = 0;
		w = eff_width();
		case (k)
			KIND_START: begin
				col_cnt   = 0;
				row_cnt   = 0;
				phase     = 0;
				partial   = '0;
				left_px   = '0;
				upleft_px = '0;
				rect_idle = (w == 0 || reg_height == 0);
			end
			KIND_PALW: begin
				colour_tbl[pidx] = pcol;
			end
			KIND_DATA: begin
				if (!rect_idle) begin
					if (reg_mode == MODE_PALETTE && reg_colors <= 2) begin
						// one bit per pixel, MSB first; a byte past the row end
						// still yields one pixel
						cnt = (w > col_cnt) ? w - col_cnt : 1;
						if (cnt > 8)
							cnt = 8;
						for (int i = 0; i < cnt && !rect_idle; i++) begin
							push_pixel(colour_tbl[b[7 - i]]);
							n++;
						end
					end else if (reg_mode == MODE_PALETTE) begin
						push_pixel(colour_tbl[b]);
						n++;
					end else if (phase < 2) begin
						// collect R and G; the triple survives a mode change
						partial = {partial[7:0], b};
						phase++;
					end else begin
						rgb     = {partial, b};
						phase   = 0;
						partial = '0;
						if (reg_mode == MODE_GRADIENT)
							rgb = predict_gradient(rgb);
						push_pixel(rgb);
						n++;
					end
					if (n > 0)
						pending_pixels[pending_pixels.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Channel drivers
	// ------------------------------------------------------------------

	// Offer one input word after a random gap; hold until accepted. Valid is
	// left high so a following word goes out without a bubble.
	task automatic send_word(logic [1:0] k, logic [7:0] pidx, logic [23:0] pcol,
			logic [7:0] b);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		palette_index <= pidx;
		palette_color <= pcol;
		data_byte     <= b;
		do @(posedge clk); while (!in_ready);
		decode_word(k, pidx, pcol, b);
	endtask

	task automatic send_start();
		send_word(KIND_START, 8'($urandom), 24'($urandom), 8'($urandom));
	endtask

	task automatic send_pal(logic [7:0] idx, logic [23:0] color);
		send_word(KIND_PALW, idx, color, 8'($urandom));
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(KIND_DATA, 8'($urandom), 24'($urandom), b);
	endtask

	task automatic send_noise();
		send_word(KIND_UNUSED, 8'($urandom), 24'($urandom), 8'($urandom));
	endtask

	// Favor the channel extremes so the gradient clamps both ways.
	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Index bytes only name entries that were loaded.
	function automatic logic [7:0] loaded_index();
		if ($urandom_range(8) == 0)
			return 8'(PALETTE_DEPTH - 1);
		return 8'($urandom_range(LOADED_ENTRIES - 1));
	endfunction

	task automatic send_random_bytes(int unsigned count);
		repeat (count) send_byte(rand_byte());
	endtask

	// Drop valid, drain every expected pixel, then let the pipeline settle:
	// words that yield no pixel may still be in flight.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:   reg_mode   = val[1:0];
			REG_COLORS: reg_colors = val[8:0];
			REG_WIDTH:  reg_width  = val[11:0];
			REG_HEIGHT: reg_height = val;
			default: ;
		endcase
	endtask

	// Write all four registers back to back once the decoder has gone quiet.
	task automatic configure(logic [1:0] mode, logic [8:0] colors, logic [11:0] width,
			logic [15:0] height);
		quiesce();
		write_reg(REG_MODE, 16'(mode));
		write_reg(REG_COLORS, 16'(colors));
		write_reg(REG_WIDTH, 16'(width));
		write_reg(REG_HEIGHT, height);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker, watchdog
	// ------------------------------------------------------------------

	// Stall at random; on request hold ready low for a long stretch so the
	// command queue fills and the input side backs up.
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Compare every accepted pixel with the oldest prediction.
	always @(posedge clk) begin : pixel_checker
		pixel_t want;
		pixel_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{pixel_color, pixel_x, pixel_y, last_of_item, rect_done};
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel color %06h x %0d y %0d last %0b done %0b",
					$time, got.color, got.x, got.y, got.last, got.done);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: pixel mismatch", $time);
					$display("  expected color %06h x %0d y %0d last %0b done %0b",
						want.color, want.x, want.y, want.last, want.done);
					$display("  actual   color %06h x %0d y %0d last %0b done %0b",
						got.color, got.x, got.y, got.last, got.done);
				end
			end
		end
	end

	// End the run if no word moves on any channel for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset the decoder waits for a start: data and unused kinds drop.
	task automatic test_idle_words();
		send_byte(8'hA5);
		send_noise();
		send_byte(8'h00);
	endtask

	// Load the low entries and the top entry; index bytes never name others.
	task automatic test_palette_load();
		send_pal(8'h00, 24'h000000);
		send_pal(8'h01, 24'hFFFFFF);
		for (int i = 2; i < LOADED_ENTRIES; i++)
			send_pal(8'(i), 24'($urandom));
		send_pal(8'(PALETTE_DEPTH - 1), 24'hFFFFFF);
	endtask

	// Copy mode, restart mid-rectangle, bytes past the end, reserved mode.
	task automatic test_copy_rect();
		configure(MODE_COPY, 9'd2, 12'd2, 16'd2);
		send_start();
		send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'h5A);          // leave a partial triple behind
		send_start();              // abandon and restart
		send_random_bytes(12);
		send_random_bytes(2);      // past the last pixel: dropped
		configure(MODE_RESERVED, 9'd2, 12'd1, 16'd1);
		send_start();
		send_random_bytes(4);
	endtask

	// One bit per pixel with row padding, zero and one colors, and a width
	// shrunk mid-row so the next byte lands past the row end.
	task automatic test_one_bit();
		configure(MODE_PALETTE, 9'd2, 12'd10, 16'd2);
		send_start();
		send_byte(8'hA5); send_byte(8'hC0);
		send_byte(8'hFF); send_byte(8'h00);
		configure(MODE_PALETTE, 9'd0, 12'd10, 16'd3);
		send_start();
		send_byte(8'h5A);
		configure(MODE_PALETTE, 9'd1, 12'd4, 16'd3);
		send_byte(8'h80); send_byte(8'h3C); send_byte(8'hF0);
	endtask

	// Index per byte, including indexes at and past the color count.
	task automatic test_index_mode();
		configure(MODE_PALETTE, 9'd3, 12'd3, 16'd2);
		send_start();
		send_byte(8'h00); send_byte(8'hFF); send_byte(8'h07);
		send_byte(8'h02); send_byte(8'h03); send_byte(8'h01);
		send_byte(8'h7E);
	endtask

	// Gradient over full-scale channel values so the estimate clamps high
	// and low.
	task automatic test_gradient();
		configure(MODE_GRADIENT, 9'd2, 12'd3, 16'd2);
		send_start();
		repeat (18) send_byte($urandom_range(1) ? 8'hFF : 8'h00);
	endtask

	// A partial triple from copy mode completes as a gradient pixel.
	task automatic test_mode_switch();
		configure(MODE_COPY, 9'd2, 12'd4, 16'd1);
		send_start();
		send_byte(8'h11); send_byte(8'h22);
		configure(MODE_GRADIENT, 9'd2, 12'd4, 16'd1);
		send_byte(8'h33);
		send_random_bytes(3);
	endtask

	// Width past the line buffer saturates, so a short run of bytes stays in
	// the first row. Then empty rectangles from a zero width and a zero height.
	task automatic test_extreme_sizes();
		configure(MODE_PALETTE, 9'd1, 12'hFFF, 16'hFFFF);
		send_start();
		send_random_bytes(4);
		configure(MODE_COPY, 9'd2, 12'd0, 16'd5);
		send_start();
		send_random_bytes(3);
		configure(MODE_COPY, 9'd2, 12'd5, 16'd0);
		send_start();
		send_random_bytes(3);
	endtask

	// Keep offering eight-pixel bytes while the receiver holds off.
	task automatic test_backpressure();
		configure(MODE_PALETTE, 9'd2, 12'd32, 16'd2);
		calm = 1'b1;
		send_start();
		hold_req = 1'b1;
		send_random_bytes(8);
		calm = 1'b0;
	endtask

	// Well-formed rectangles of random shape and content, with noise words,
	// palette rewrites, trailing bytes and abandoned rectangles mixed in.
	task automatic test_random();
		int unsigned counted;
		int unsigned w;
		int unsigned h;
		int unsigned need;
		int unsigned nbytes;
		logic [1:0]  mode;
		logic [8:0]  colors;
		bit          one_bit;
		bit          index_mode;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = (counted < CALM_ITEMS);   // steady stretch first
			if (counted == 0 || $urandom_range(3) != 0) begin
				mode = 2'($urandom_range(3));
				case ($urandom_range(5))
					0: colors = 9'd0;
					1: colors = 9'd1;
					2: colors = 9'd2;
					3: colors = 9'd3;
					4: colors = 9'd256;
					default: colors = 9'($urandom_range(511));
				endcase
				one_bit = (mode == MODE_PALETTE && colors <= 2);
				w = one_bit ? $urandom_range(1, 24) : $urandom_range(1, 4);
				h = one_bit ? $urandom_range(1, 3) : $urandom_range(1, 2);
				configure(mode, colors, 12'(w), 16'(h));
			end
			one_bit    = (reg_mode == MODE_PALETTE && reg_colors <= 2);
			index_mode = (reg_mode == MODE_PALETTE && !one_bit);
			if (one_bit)
				need = ((reg_width + 7) / 8) * reg_height;
			else if (index_mode)
				need = reg_width * reg_height;
			else
				need = 3 * reg_width * reg_height;
			nbytes = need;
			if ($urandom_range(7) == 0 && need > 1)
				nbytes = $urandom_range(1, need - 1);   // abandon midway
			send_start();
			counted++;
			for (int i = 0; i < nbytes; i++) begin
				case ($urandom_range(19))
					0: begin
						send_pal(8'($urandom), 24'($urandom));
						counted++;
					end
					1: send_noise();
					default: ;
				endcase
				send_byte(index_mode ? loaded_index() : rand_byte());
				counted++;
			end
			if (nbytes == need)
				send_random_bytes($urandom_range(2));
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_words();
		test_palette_load();
		test_copy_rect();
		test_one_bit();
		test_index_mode();
		test_gradient();
		test_mode_switch();
		test_extreme_sizes();
		test_backpressure();
		test_random();

		quiesce();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
